>>> hdl/bra_pkg.sv
package bra_pkg;

  // Resource count is fixed by the per-resource ports of the top level
  localparam int NUM_RESOURCES = 4;

  localparam int DEF_NUM_CUSTOMERS = 5;
  localparam int DEF_COUNT_WIDTH   = 8;

  // Register index of the resource totals; customer c maximum sits at 1 + c
  localparam int CFG_INIT_AVAIL = 0;
  localparam int CFG_MAX_BASE   = 1;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_INVALID    = 3'd1,
    ST_OVER_NEED  = 3'd2,
    ST_OVER_AVAIL = 3'd3,
    ST_UNSAFE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } scan_state_t;

  typedef struct packed {
    logic busy;
    logic fin;
    logic safe;
  } scan_stat_t;

endpackage

>>> hdl/bra_lane.sv
module bra_lane #(
  parameter int COUNT_WIDTH = bra_pkg::DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   add,
  input  logic [COUNT_WIDTH-1:0] work_init,
  input  logic [COUNT_WIDTH-1:0] alloc_r,
  input  logic [COUNT_WIDTH-1:0] max_r,
  output logic                   fit
);
  import bra_pkg::*;

  logic [COUNT_WIDTH-1:0] work;
  logic [COUNT_WIDTH-1:0] need;

  // work never exceeds the larger of the total and the allocated sum, so no wrap
  always_ff @(posedge clk) begin
    if (load) begin
      work <= work_init;
    end else if (add) begin
      work <= work + alloc_r;
    end
  end

  assign need = (max_r > alloc_r) ? (max_r - alloc_r) : '0;
  assign fit  = (need <= work);

endmodule

>>> hdl/bra_scan.sv
module bra_scan #(
  parameter int NUM_CUSTOMERS = bra_pkg::DEF_NUM_CUSTOMERS,
  parameter int COUNT_WIDTH   = bra_pkg::DEF_COUNT_WIDTH,
  parameter int CI_W          = $clog2(NUM_CUSTOMERS)
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             start,
  input  logic [bra_pkg::NUM_RESOURCES-1:0][COUNT_WIDTH-1:0] work_init,
  input  logic [bra_pkg::NUM_RESOURCES-1:0][COUNT_WIDTH-1:0] alloc_row,
  input  logic [bra_pkg::NUM_RESOURCES-1:0][COUNT_WIDTH-1:0] max_row,
  output logic [CI_W-1:0]                                  scan_cust,
  output bra_pkg::scan_stat_t                              stat
);
  import bra_pkg::*;

  scan_state_t              sstate, sstate_next;
  logic [CI_W-1:0]          idx;
  logic [NUM_CUSTOMERS-1:0] done, done_set;
  logic                     progress;
  logic                     safe;
  logic                     fin;
  logic [NUM_RESOURCES-1:0] lane_fit;
  logic                     fits;
  logic                     pass_end;
  logic                     all_done;
  logic                     finish;

  for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_lane
    bra_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk      (clk),
      .load     (start),
      .add      (fits),
      .work_init(work_init[r]),
      .alloc_r  (alloc_row[r]),
      .max_r    (max_row[r]),
      .fit      (lane_fit[r])
    );
  end

  // merge: customer finishes only if every resource lane fits
  always_comb begin
    fits     = (sstate == SC_RUN) && !done[idx] && (&lane_fit);
    done_set = done;
    if (fits) begin
      done_set[idx] = 1'b1;
    end
    pass_end = (idx == CI_W'(NUM_CUSTOMERS - 1));
    all_done = &done_set;
    finish   = (sstate == SC_RUN) && (all_done || (pass_end && !(progress || fits)));
  end

  always_comb begin
    sstate_next = sstate;
    case (sstate)
      SC_IDLE: if (start) sstate_next = SC_RUN;
      SC_RUN:  if (finish) sstate_next = SC_IDLE;
      default: sstate_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sstate   <= SC_IDLE;
      idx      <= '0;
      done     <= '0;
      progress <= 1'b0;
      safe     <= 1'b0;
      fin      <= 1'b0;
    end else begin
      sstate <= sstate_next;
      fin    <= finish;
      if (start) begin
        idx      <= '0;
        done     <= '0;
        progress <= 1'b0;
      end else if (sstate == SC_RUN) begin
        done <= done_set;
        if (finish) begin
          safe <= all_done;
        end else if (pass_end) begin
          idx      <= '0;
          progress <= 1'b0;
        end else begin
          idx      <= idx + 1'b1;
          progress <= progress | fits;
        end
      end
    end
  end

  assign scan_cust = idx;
  assign stat.busy = (sstate == SC_RUN);
  assign stat.fin  = fin;
  assign stat.safe = safe;

  a_fin_safe: assert property (@(posedge clk) disable iff (rst)
    fin |-> (safe == (&done)))
    else $error("scan verdict disagrees with finished set");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.busy) |-> (done == '0) && (idx == '0))
    else $error("scan started with stale state");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("scan restarted while running");

endmodule

>>> hdl/bankers_resource_allocator.sv
// Banker's allocator: one request or release at a time.
// A result is registered once the check state, and for a request the scan, is through; a request that reaches the
// safety scan adds one customer per cycle over up to NUM_CUSTOMERS passes before
// the verdict is registered.
// A new request is accepted only in the idle state; a waiting result does not block input.
// Reset (rst, synchronous): allocations, totals, configuration and control state cleared.
module bankers_resource_allocator #(
  parameter int NUM_CUSTOMERS = bra_pkg::DEF_NUM_CUSTOMERS,
  parameter int COUNT_WIDTH   = bra_pkg::DEF_COUNT_WIDTH,
  parameter int CUST_W        = $clog2(NUM_CUSTOMERS + 1),
  parameter int REG_W         = bra_pkg::NUM_RESOURCES * COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CUST_W-1:0]      cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [CUST_W-1:0]      customer,
  input  logic [COUNT_WIDTH-1:0] amount_0,
  input  logic [COUNT_WIDTH-1:0] amount_1,
  input  logic [COUNT_WIDTH-1:0] amount_2,
  input  logic [COUNT_WIDTH-1:0] amount_3,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status,
  output logic [COUNT_WIDTH-1:0] avail_0,
  output logic [COUNT_WIDTH-1:0] avail_1,
  output logic [COUNT_WIDTH-1:0] avail_2,
  output logic [COUNT_WIDTH-1:0] avail_3
);
  import bra_pkg::*;

  localparam int CI_W = $clog2(NUM_CUSTOMERS);
  localparam int NR   = NUM_RESOURCES;
  localparam int W    = COUNT_WIDTH;

  typedef logic [NR-1:0][W-1:0] row_t;

  row_t init_avail;
  row_t max_tab   [NUM_CUSTOMERS];
  row_t alloc_tab [NUM_CUSTOMERS];
  row_t tot;

  state_t       state, state_next;
  logic         req_op;
  logic [CUST_W-1:0] req_cust;
  row_t         req_amt;
  status_t      pend_status, pend_next;
  status_t      out_status;
  row_t         out_avail;

  logic [CI_W-1:0] req_idx;
  logic            cust_ok;
  logic [CI_W-1:0] rd_c;
  logic            rd_ok;
  logic            scanning;
  row_t            alloc_rd, max_rd;
  row_t            alloc_tent;
  row_t            work_init;
  row_t            give;
  row_t            avail_now;
  logic            over_need, over_avail;
  logic [W:0]      tot_sum;

  logic [CI_W-1:0] scan_cust;
  scan_stat_t      scan_stat;

  logic in_accept;
  logic out_free;
  logic scan_start;
  logic commit_rel;
  logic commit_req;
  logic out_load;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign req_idx   = req_cust[CI_W-1:0];
  assign cust_ok   = (req_cust < CUST_W'(NUM_CUSTOMERS));
  assign scanning  = (state == S_SCAN) && !scan_stat.fin;

  // single read port into the tables: scan customer while scanning, else requester
  assign rd_c  = scanning ? scan_cust : req_idx;
  assign rd_ok = (int'(rd_c) < NUM_CUSTOMERS);

  always_comb begin
    alloc_rd   = rd_ok ? alloc_tab[rd_c] : '0;
    max_rd     = rd_ok ? max_tab[rd_c] : '0;
    over_need  = 1'b0;
    over_avail = 1'b0;
    for (int r = 0; r < NR; r++) begin
      avail_now[r]  = (init_avail[r] > tot[r]) ? (init_avail[r] - tot[r]) : '0;
      alloc_tent[r] = alloc_rd[r] + ((scanning && (rd_c == req_idx)) ? req_amt[r] : '0);
      tot_sum       = {1'b0, tot[r]} + {1'b0, req_amt[r]};
      work_init[r]  = ({1'b0, init_avail[r]} > tot_sum) ?
                      W'({1'b0, init_avail[r]} - tot_sum) : '0;
      give[r]       = (req_amt[r] > alloc_rd[r]) ? alloc_rd[r] : req_amt[r];
      if (req_amt[r] > ((max_rd[r] > alloc_rd[r]) ? (max_rd[r] - alloc_rd[r]) : '0)) begin
        over_need = 1'b1;
      end
      if (req_amt[r] > avail_now[r]) begin
        over_avail = 1'b1;
      end
    end
  end

  bra_scan #(
    .NUM_CUSTOMERS(NUM_CUSTOMERS),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CI_W         (CI_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .work_init(work_init),
    .alloc_row(alloc_tent),
    .max_row  (max_rd),
    .scan_cust(scan_cust),
    .stat     (scan_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_accept) state_next = S_CHECK;
      S_CHECK: begin
        if (cust_ok && (req_op == OP_REQUEST) && !over_need && !over_avail) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN:  if (scan_stat.fin) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    scan_start = 1'b0;
    commit_rel = 1'b0;
    commit_req = 1'b0;
    out_load   = 1'b0;
    pend_next  = pend_status;
    case (state)
      S_CHECK: begin
        if (!cust_ok) begin
          pend_next = ST_INVALID;
        end else if (req_op == OP_RELEASE) begin
          pend_next  = ST_DONE;
          commit_rel = 1'b1;
        end else if (over_need) begin
          pend_next = ST_OVER_NEED;
        end else if (over_avail) begin
          pend_next = ST_OVER_AVAIL;
        end else begin
          scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_stat.fin) begin
          pend_next  = scan_stat.safe ? ST_DONE : ST_UNSAFE;
          commit_req = scan_stat.safe;
        end
      end
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend_status <= ST_DONE;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pend_status <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_op   <= op;
      req_cust <= customer;
      req_amt  <= {amount_3, amount_2, amount_1, amount_0};
    end
    if (out_load) begin
      out_status <= pend_status;
      out_avail  <= avail_now;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_avail <= '0;
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
        max_tab[c] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CUST_W'(CFG_INIT_AVAIL)) begin
        init_avail <= cfg_data;
      end
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
        if (cfg_index == CUST_W'(CFG_MAX_BASE + c)) begin
          max_tab[c] <= cfg_data;
        end
      end
    end
  end

  // allocation state; rd_c equals req_idx on both commit cycles
  always_ff @(posedge clk) begin
    if (rst) begin
      tot <= '0;
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
        alloc_tab[c] <= '0;
      end
    end else if (commit_rel) begin
      for (int r = 0; r < NR; r++) begin
        alloc_tab[req_idx][r] <= alloc_rd[r] - give[r];
        tot[r]                <= tot[r] - give[r];
      end
    end else if (commit_req) begin
      for (int r = 0; r < NR; r++) begin
        alloc_tab[req_idx][r] <= alloc_rd[r] + req_amt[r];
        tot[r]                <= tot[r] + req_amt[r];
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign status   = out_status;
  assign avail_0  = out_avail[0];
  assign avail_1  = out_avail[1];
  assign avail_2  = out_avail[2];
  assign avail_3  = out_avail[3];

  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_stat.fin |-> (state == S_SCAN))
    else $error("scan verdict outside scan state");

  a_scan_alive: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_stat.busy || scan_stat.fin))
    else $error("waiting on an idle scan");

  a_commit_one: assert property (@(posedge clk) disable iff (rst)
    (commit_rel || commit_req) |-> cust_ok && !(commit_rel && commit_req))
    else $error("commit for invalid customer or double commit");

endmodule
